>>> design/rgb_color_card_classifier_core_defines.svh
// Assertion macros for the color card classifier core.
// Included by the top level; depends on nothing else.
`ifndef RGB_COLOR_CARD_CLASSIFIER_CORE_DEFINES_SVH
`define RGB_COLOR_CARD_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RCCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rccc check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define RCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rccc check failed: next-cycle rule");

`endif

>>> design/rccc_pkg.sv
// Shared types and constants of the color card classifier core.
// No dependencies; imported by every module of the core.
`default_nettype none
package rccc_pkg;

	localparam int CntW  = 16;
	localparam int ClsW  = 3;
	localparam int IdxW  = 3;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	// color classes
	localparam logic [ClsW-1:0] CLS_DARK    = 3'd0;
	localparam logic [ClsW-1:0] CLS_WHITE   = 3'd1;
	localparam logic [ClsW-1:0] CLS_YELLOW  = 3'd2;
	localparam logic [ClsW-1:0] CLS_RED     = 3'd3;
	localparam logic [ClsW-1:0] CLS_GREEN   = 3'd4;
	localparam logic [ClsW-1:0] CLS_BLUE    = 3'd5;
	localparam logic [ClsW-1:0] CLS_UNKNOWN = 3'd6;

	// register indexes
	localparam logic [IdxW-1:0] REG_DARK_LEVEL     = 3'd0;
	localparam logic [IdxW-1:0] REG_WHITE_LEVEL    = 3'd1;
	localparam logic [IdxW-1:0] REG_WHITE_SPAN_MAX = 3'd2;
	localparam logic [IdxW-1:0] REG_RATIO_MIN      = 3'd3;
	localparam logic [IdxW-1:0] REG_DOMINANT_MIN   = 3'd4;

	// fixed fractions of clear, in 1/256
	localparam logic [7:0] FRAC_YEL_BLUE_MAX = 8'd77;
	localparam logic [7:0] FRAC_YEL_RG_MIN   = 8'd97;
	localparam logic [7:0] FRAC_YEL_DIFF_MAX = 8'd46;
	localparam logic [7:0] FRAC_RG_BLUE_MAX  = 8'd115;
	localparam logic [7:0] FRAC_BLUE_MIN     = 8'd90;

	typedef logic [ClsW-1:0] class_t;

	typedef struct packed {
		logic [15:0] dark_level;
		logic [15:0] white_level;
		logic [7:0]  white_span_max;
		logic [9:0]  ratio_min;
		logic [7:0]  dominant_min;
	} cfg_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [QCntW-1:0] count;
	} qstat_t;

endpackage
`default_nettype wire

>>> design/rccc_front.sv
// Front end: accepts samples, clamps them and classifies them.
// Depends on rccc_pkg; feeds rccc_queue.
`default_nettype none
module rccc_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire rccc_pkg::cfg_t      cfg,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire [rccc_pkg::CntW-1:0] clear_count,
	input  wire [rccc_pkg::CntW-1:0] red_count,
	input  wire [rccc_pkg::CntW-1:0] green_count,
	input  wire [rccc_pkg::CntW-1:0] blue_count,
	input  wire                      q_full,
	output logic                     push,
	output rccc_pkg::class_t         push_class
);
	import rccc_pkg::*;

	// 256*x > k*c
	function automatic logic frac_gt(input logic [15:0] x, input logic [7:0] k,
		input logic [15:0] c);
		logic [23:0] lhs;
		logic [23:0] rhs;
		lhs = {x, 8'h00};
		rhs = 24'(k) * 24'(c);
		return lhs > rhs;
	endfunction

	// 256*x < k*c
	function automatic logic frac_lt(input logic [15:0] x, input logic [7:0] k,
		input logic [15:0] c);
		logic [23:0] lhs;
		logic [23:0] rhs;
		lhs = {x, 8'h00};
		rhs = 24'(k) * 24'(c);
		return lhs < rhs;
	endfunction

	// num/den > qmin/256, a zero den always passes
	function automatic logic ratio_gt(input logic [15:0] num, input logic [15:0] den,
		input logic [9:0] qmin);
		logic [25:0] lhs;
		logic [25:0] rhs;
		lhs = {2'b00, num, 8'h00};
		rhs = 26'(qmin) * 26'(den);
		return (den == '0) || (lhs > rhs);
	endfunction

	logic        valid_s1;
	logic        dark_s1, wlvl_s1;
	logic [15:0] c_s1, r_s1, g_s1, b_s1, span_s1, diff_s1;

	logic [15:0] c_d, r_d, g_d, b_d, hi_d, lo_d;
	logic        advance;

	assign advance  = !valid_s1 || !q_full;
	assign in_ready = advance;

	always_comb begin
		c_d  = (clear_count == '0) ? 16'd1 : clear_count;
		r_d  = (red_count   < c_d) ? red_count   : c_d;
		g_d  = (green_count < c_d) ? green_count : c_d;
		b_d  = (blue_count  < c_d) ? blue_count  : c_d;
		hi_d = (r_d > g_d) ? r_d : g_d;
		hi_d = (hi_d > b_d) ? hi_d : b_d;
		lo_d = (r_d < g_d) ? r_d : g_d;
		lo_d = (lo_d < b_d) ? lo_d : b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			dark_s1 <= clear_count < cfg.dark_level;
			wlvl_s1 <= clear_count > cfg.white_level;
			c_s1    <= c_d;
			r_s1    <= r_d;
			g_s1    <= g_d;
			b_s1    <= b_d;
			span_s1 <= hi_d - lo_d;
			diff_s1 <= (r_d > g_d) ? (r_d - g_d) : (g_d - r_d);
		end
	end

	logic is_white, is_yellow, is_red, is_green, is_blue, rg_blue_ok;

	always_comb begin
		is_white   = frac_lt(span_s1, cfg.white_span_max, c_s1) && wlvl_s1;
		is_yellow  = frac_lt(b_s1, FRAC_YEL_BLUE_MAX, c_s1) &&
			frac_gt(r_s1, FRAC_YEL_RG_MIN, c_s1) &&
			frac_gt(g_s1, FRAC_YEL_RG_MIN, c_s1) &&
			frac_lt(diff_s1, FRAC_YEL_DIFF_MAX, c_s1);
		rg_blue_ok = frac_lt(b_s1, FRAC_RG_BLUE_MAX, c_s1);
		is_red     = ratio_gt(r_s1, g_s1, cfg.ratio_min) &&
			frac_gt(r_s1, cfg.dominant_min, c_s1) && rg_blue_ok;
		is_green   = ratio_gt(g_s1, r_s1, cfg.ratio_min) &&
			frac_gt(g_s1, cfg.dominant_min, c_s1) && rg_blue_ok;
		is_blue    = (b_s1 > r_s1) && (b_s1 > g_s1) && frac_gt(b_s1, FRAC_BLUE_MIN, c_s1);

		if (dark_s1)        push_class = CLS_DARK;
		else if (is_white)  push_class = CLS_WHITE;
		else if (is_yellow) push_class = CLS_YELLOW;
		else if (is_red)    push_class = CLS_RED;
		else if (is_green)  push_class = CLS_GREEN;
		else if (is_blue)   push_class = CLS_BLUE;
		else                push_class = CLS_UNKNOWN;
	end

	assign push = valid_s1 && !q_full;

endmodule
`default_nettype wire

>>> design/rccc_queue.sv
// Small flop FIFO of classes between the front and back ends.
// Depends on rccc_pkg.
`default_nettype none
module rccc_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire rccc_pkg::class_t   push_data,
	input  wire                     pop,
	output rccc_pkg::class_t        pop_data,
	output rccc_pkg::qstat_t        stat
);
	import rccc_pkg::*;

	class_t             mem_q [QDepth];
	logic [QPtrW-1:0]   wptr_q, rptr_q;
	logic [QCntW-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	assign pop_data   = mem_q[rptr_q];
	assign stat.count = count_q;
	assign stat.full  = count_q == QCntW'(QDepth);
	assign stat.empty = count_q == '0;

endmodule
`default_nettype wire

>>> design/rccc_back.sv
// Back end: output register that drains the queue onto the result stream.
// Depends on rccc_pkg.
`default_nettype none
module rccc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rccc_pkg::qstat_t qstat,
	input  wire rccc_pkg::class_t q_data,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output rccc_pkg::class_t      out_class
);
	import rccc_pkg::*;

	logic   valid_q;
	class_t class_q;

	assign pop = !qstat.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) class_q <= q_data;
	end

	assign out_valid = valid_q;
	assign out_class = class_q;

endmodule
`default_nettype wire

>>> design/rgb_color_card_classifier_core.sv
// Top level of the color card classifier: config registers, front end, queue, back end.
// Depends on rccc_pkg, rccc_front, rccc_queue, rccc_back and the defines header.
`default_nettype none
`include "rgb_color_card_classifier_core_defines.svh"
// Classifies one sample of clear/red/green/blue counts per beat into a color class
// (0 dark, 1 white, 2 yellow, 3 red, 4 green, 5 blue, 6 unknown), rules tried in that
// order. Throughput is one sample per clock while the queue has room. The accepting edge
// loads the clamp stage, the compared class is then written into the four-entry queue,
// and from there it is loaded into the output register. All fraction and ratio tests are
// constant or register cross-multiplications, so there is no divider.
// The front end keeps accepting while the queue has room. Up to six samples can be in
// flight: the output register, four queue entries and the compare stage. s_axis_tready
// drops once the queue is full and the compare stage holds a sample. Config writes are
// always taken (cfg_ready is tied high) and should only be issued while the block is
// empty; writes to indexes above 4 are dropped.
module rgb_color_card_classifier_core (
	input  wire        clk,
	input  wire        arst_n,
	// sample stream; tdata: clear_count[15:0], red_count[31:16],
	// green_count[47:32], blue_count[63:48]
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [63:0] s_axis_tdata,
	// result stream; tdata: color_class[2:0], zero pad [7:3]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,
	// config write channel
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_data
);
	import rccc_pkg::*;

	cfg_t   cfg_q;
	qstat_t q_stat;
	class_t push_class, q_data, out_class;
	logic   push, pop;

	assign cfg_ready = 1'b1;

	// register file, loaded by index; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_level     <= 16'd80;
			cfg_q.white_level    <= 16'd120;
			cfg_q.white_span_max <= 8'd26;
			cfg_q.ratio_min      <= 10'd346;
			cfg_q.dominant_min   <= 8'd82;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DARK_LEVEL:     cfg_q.dark_level     <= cfg_data;
				REG_WHITE_LEVEL:    cfg_q.white_level    <= cfg_data;
				REG_WHITE_SPAN_MAX: cfg_q.white_span_max <= cfg_data[7:0];
				REG_RATIO_MIN:      cfg_q.ratio_min      <= cfg_data[9:0];
				REG_DOMINANT_MIN:   cfg_q.dominant_min   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front end: clamp stage, then compare/priority into the queue
	rccc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.clear_count (s_axis_tdata[15:0]),
		.red_count   (s_axis_tdata[31:16]),
		.green_count (s_axis_tdata[47:32]),
		.blue_count  (s_axis_tdata[63:48]),
		.q_full      (q_stat.full),
		.push        (push),
		.push_class  (push_class)
	);

	// decouples the compare stage from output stalls
	rccc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_class),
		.pop       (pop),
		.pop_data  (q_data),
		.stat      (q_stat)
	);

	// back end: output register
	rccc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (q_stat),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_class (out_class)
	);

	assign m_axis_tdata = {5'b00000, out_class};

	// queue never overflows or underflows, and its count tracks push/pop
	`RCCC_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !q_stat.full)
	`RCCC_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty)
	`RCCC_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop,
		q_stat.count == $past(q_stat.count) + 1'b1)
	`RCCC_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push,
		q_stat.count == $past(q_stat.count) - 1'b1)

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for rgb_color_card_classifier_core: classifies random and
// directed RGBC samples under several register settings and checks every result.
// Depends on rccc_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
	import rccc_pkg::*;

	localparam int          HALF_PERIOD  = 5;
	localparam int          RESET_CYCLES = 7;
	localparam int          DRAIN_CYCLES = 8;    // pipeline is three deep, pad a little
	localparam int          HOLD_CYCLES  = 60;   // long output stall for the pressure test
	localparam int unsigned LIMIT_CYCLES = 200000;

	// fixed fractions of clear, in 1/256 (rounded from the original float thresholds)
	localparam logic [31:0] YEL_BLUE_CAP  = 32'd77;
	localparam logic [31:0] YEL_RG_FLOOR  = 32'd97;
	localparam logic [31:0] YEL_GAP_CAP   = 32'd46;
	localparam logic [31:0] RG_BLUE_CAP   = 32'd115;
	localparam logic [31:0] BLUE_FLOOR    = 32'd90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [7:0]  m_axis_tdata;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	cfg_t        cur_cfg;                 // register copy used by the predictor
	class_t      expected_classes[$];
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned hold_seq = 0;            // bumped by the test to request a long stall
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	rgb_color_card_classifier_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// ratio num/den above q/256; a zero denominator always passes
	function automatic bit ratio_above(input logic [31:0] num, input logic [31:0] den,
			input logic [31:0] q);
		if (den == 0)
			return 1'b1;
		return (32'd256 * num) > (q * den);
	endfunction

	function automatic class_t predict_class(input logic [63:0] sample, input cfg_t cf);
		logic [31:0] raw_c, c, r, g, b, hi, lo, gap;
		logic [31:0] span_k, dom_k, q;
		raw_c  = {16'd0, sample[15:0]};
		span_k = {24'd0, cf.white_span_max};
		dom_k  = {24'd0, cf.dominant_min};
		q      = {22'd0, cf.ratio_min};
		// dark test works on the raw clear count
		if (raw_c < {16'd0, cf.dark_level})
			return CLS_DARK;
		c = (raw_c == 0) ? 32'd1 : raw_c;
		// channels never exceed clear
		r = ({16'd0, sample[31:16]} < c) ? {16'd0, sample[31:16]} : c;
		g = ({16'd0, sample[47:32]} < c) ? {16'd0, sample[47:32]} : c;
		b = ({16'd0, sample[63:48]} < c) ? {16'd0, sample[63:48]} : c;
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		if ((32'd256 * (hi - lo)) < (span_k * c) && raw_c > {16'd0, cf.white_level})
			return CLS_WHITE;
		gap = (r > g) ? r - g : g - r;
		if ((32'd256 * b) < (YEL_BLUE_CAP * c) && (32'd256 * r) > (YEL_RG_FLOOR * c) &&
				(32'd256 * g) > (YEL_RG_FLOOR * c) && (32'd256 * gap) < (YEL_GAP_CAP * c))
			return CLS_YELLOW;
		if (ratio_above(r, g, q) && (32'd256 * r) > (dom_k * c) &&
				(32'd256 * b) < (RG_BLUE_CAP * c))
			return CLS_RED;
		if (ratio_above(g, r, q) && (32'd256 * g) > (dom_k * c) &&
				(32'd256 * b) < (RG_BLUE_CAP * c))
			return CLS_GREEN;
		if (b > r && b > g && (32'd256 * b) > (BLUE_FLOOR * c))
			return CLS_BLUE;
		return CLS_UNKNOWN;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// base * k / 256 with a little jitter, saturated to 16 bits
	function automatic logic [15:0] scaled(input logic [15:0] base, input int unsigned k);
		int v;
		int jit;
		jit = int'($urandom_range(4)) - 2;
		v = (int'(base) * int'(k)) / 256 + jit;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// random sample aimed mostly at the decision boundaries of each class
	function automatic logic [63:0] make_sample(input cfg_t cf);
		logic [15:0] c, r, g, b, base, tmp;
		int unsigned pick;
		case ($urandom_range(4))
			0: c = 16'($urandom_range(1023));
			1: c = 16'($urandom_range(65535));
			2: c = 16'($urandom_range(255, 8191));
			3: c = scaled(cf.white_level, $urandom_range(240, 272));
			default: c = scaled(cf.dark_level, $urandom_range(240, 272));
		endcase
		pick = $urandom_range(99);
		if (pick < 10) begin
			// noise
			c = 16'($urandom);
			r = 16'($urandom);
			g = 16'($urandom);
			b = 16'($urandom);
		end else if (pick < 25) begin
			// yellow: strong red and green, close together, little blue
			r = scaled(c, $urandom_range(80, 170));
			g = scaled(r, $urandom_range(190, 320));
			b = scaled(c, $urandom_range(100));
		end else if (pick < 45) begin
			// red or green: one dominant channel near the ratio limit
			r = scaled(c, $urandom_range(50, 300));
			g = scaled(r, $urandom_range(256));
			b = scaled(c, $urandom_range(150));
			if ($urandom_range(1)) begin
				tmp = r;
				r = g;
				g = tmp;
			end
		end else if (pick < 60) begin
			// blue
			b = scaled(c, $urandom_range(60, 300));
			r = scaled(b, $urandom_range(280));
			g = scaled(b, $urandom_range(280));
		end else if (pick < 75) begin
			// flat spectrum, candidate for white
			base = scaled(c, $urandom_range(60, 300));
			r = scaled(base, $urandom_range(226, 286));
			g = scaled(base, $urandom_range(226, 286));
			b = scaled(base, $urandom_range(226, 286));
		end else if (pick < 92) begin
			r = scaled(c, $urandom_range(320));
			g = scaled(c, $urandom_range(320));
			b = scaled(c, $urandom_range(320));
		end else begin
			// tiny counts, zero clear among them
			c = 16'($urandom_range(3));
			r = 16'($urandom_range(3));
			g = 16'($urandom_range(3));
			b = 16'($urandom_range(3));
		end
		return {b, g, r, c};
	endfunction

	// one sample beat; tvalid stays high across back-to-back beats
	task automatic send_sample(input logic [63:0] sample);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sample;
		do @(posedge clk); while (!s_axis_tready);
		expected_classes.push_back(predict_class(sample, cur_cfg));
	endtask

	// stop sending and let every pending result come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_classes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DARK_LEVEL:     cur_cfg.dark_level     = val;
			REG_WHITE_LEVEL:    cur_cfg.white_level    = val;
			REG_WHITE_SPAN_MAX: cur_cfg.white_span_max = val[7:0];
			REG_RATIO_MIN:      cur_cfg.ratio_min      = val[9:0];
			REG_DOMINANT_MIN:   cur_cfg.dominant_min   = val[7:0];
			default: ;
		endcase
	endtask

	// all five registers, written only once the block has drained
	task automatic load_settings(input logic [15:0] dark, input logic [15:0] white,
			input logic [15:0] span, input logic [15:0] ratio, input logic [15:0] dom);
		wait_idle();
		write_reg(REG_DARK_LEVEL, dark);
		write_reg(REG_WHITE_LEVEL, white);
		write_reg(REG_WHITE_SPAN_MAX, span);
		write_reg(REG_RATIO_MIN, ratio);
		write_reg(REG_DOMINANT_MIN, dom);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// ---------------------------------------------------------------- tests

	// reset register values: field extremes, every class, clamping, threshold edges
	task automatic test_reset_defaults();
		send_sample({16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_sample({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_sample({16'd0, 16'd0, 16'd0, 16'd79});
		send_sample({16'd0, 16'd0, 16'd0, 16'd80});
		send_sample({16'd120, 16'd120, 16'd120, 16'd120});
		send_sample({16'd121, 16'd121, 16'd121, 16'd121});
		send_sample({16'd100, 16'd500, 16'd500, 16'd1000});
		send_sample({16'd100, 16'd100, 16'd600, 16'd1000});
		send_sample({16'd100, 16'd600, 16'd100, 16'd1000});
		send_sample({16'd600, 16'd100, 16'd100, 16'd1000});
		send_sample({16'd0, 16'd300, 16'd300, 16'd1000});
		// channels above clear, zero divisor on either side
		send_sample({16'd0, 16'd0, 16'hFFFF, 16'd100});
		send_sample({16'd0, 16'hFFFF, 16'd0, 16'd100});
		send_sample({16'd300, 16'd0, 16'd0, 16'd1000});
		send_sample({16'd400, 16'd0, 16'd0, 16'd1000});
		send_sample({16'hFFFF, 16'd0, 16'd0, 16'hFFFF});
		send_sample({16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
	endtask

	// dark_level 0 lets a zero clear count through; clear then counts as 1
	task automatic test_zero_clear();
		load_settings(16'd0, 16'd120, 16'd26, 16'd346, 16'd82);
		send_sample({16'd0, 16'd0, 16'd0, 16'd0});
		send_sample({16'd0, 16'd0, 16'd5, 16'd0});
		send_sample({16'd0, 16'd5, 16'd0, 16'd0});
		send_sample({16'd9, 16'd0, 16'd0, 16'd0});
		send_sample({16'd0, 16'd1, 16'd1, 16'd0});
		send_sample({16'd1, 16'd1, 16'd1, 16'd0});
		send_sample({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0});
	endtask

	task automatic test_random_samples(input logic [15:0] dark, input logic [15:0] white,
			input logic [15:0] span, input logic [15:0] ratio, input logic [15:0] dom,
			input int unsigned count);
		load_settings(dark, white, span, ratio, dom);
		repeat (count) send_sample(make_sample(cur_cfg));
	endtask

	// output held off long enough that the queue fills and tready drops
	task automatic test_output_stall();
		wait_idle();
		hold_seq = hold_seq + 1;
		repeat (40) send_sample(make_sample(cur_cfg));
	endtask

	// writes to indexes past the last register must not change anything
	task automatic test_ignored_index();
		logic [2:0] idx;
		wait_idle();
		for (idx = REG_DOMINANT_MIN + 3'd1; idx != 3'd0; idx = idx + 3'd1)
			write_reg(idx, 16'($urandom));
		cfg_valid <= 1'b0;
		repeat (20) send_sample(make_sample(cur_cfg));
	endtask

	// ---------------------------------------------------------------- result side

	// receiver: random stalls, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// each result beat against the oldest pending class
	always @(posedge clk) begin
		class_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_classes.size() == 0) begin
				$display("%0t: color_class expected none, got %0d", $time, m_axis_tdata);
				error_count = error_count + 1;
			end else begin
				want = expected_classes.pop_front();
				if (m_axis_tdata !== {5'd0, want}) begin
					$display("%0t: color_class expected %0d, got %0d", $time, want,
						m_axis_tdata);
					error_count = error_count + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		cur_cfg.dark_level     = 16'd80;
		cur_cfg.white_level    = 16'd120;
		cur_cfg.white_span_max = 8'd26;
		cur_cfg.ratio_min      = 10'd346;
		cur_cfg.dominant_min   = 8'd82;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(15, 75);
		test_reset_defaults();
		test_zero_clear();
		test_random_samples(16'd80, 16'd120, 16'd26, 16'd346, 16'd82, 250);
		test_random_samples(16'($urandom_range(200)), 16'($urandom_range(2000)),
			16'($urandom_range(255)), 16'($urandom_range(256, 1023)),
			16'($urandom_range(255)), 250);

		set_idling(75, 15);
		test_random_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 200);
		test_random_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
		test_random_samples(16'($urandom_range(300)), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 250);

		set_idling(0, 0);
		test_output_stall();
		test_ignored_index();
		// ratio below 1.0, upper data bits set to check the register widths
		test_random_samples(16'd0, 16'($urandom_range(500)), 16'($urandom_range(255)),
			{6'($urandom), 10'($urandom_range(255))}, 16'($urandom_range(255)), 300);

		wait_idle();
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
